/* design/assert_macros.svh */
// assertion macros shared by the display driver modules
// no dependencies; the assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define SSRD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed: %m");
// condition never seen at a clock edge outside reset
`define SSRD_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("forbidden condition: %m");
`else
`define SSRD_ASSERT(lbl, clk, rstn, prop)
`define SSRD_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* design/ssrd_pkg.sv */
// types, constants and the character table of the seven-segment display driver
// no dependencies
package ssrd_pkg;

	localparam int CNT_W = 7;

	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_ROLL  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_LOAD  = 2'd3;

	localparam logic [3:0] DIM_TOP = 4'd10;
	localparam logic [3:0] BRIGHT_RESET = 4'd10;
	localparam logic [2:0] NO_POINT = 3'd5;
	localparam logic [CNT_W-1:0] LOAD_MAX = 7'd127;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] SEG_POINT = 8'h80;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char0;
		logic [7:0] char1;
		logic [7:0] char2;
		logic [7:0] char3;
		logic [2:0] point_position;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] digit_select;
		logic [7:0] segments;
	} res_t;

	typedef struct packed {
		logic             we;
		logic [CNT_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [CNT_W-1:0] raddr;
	} mem_req_t;

	// bit 8 set when the character is known, bits 6:0 segments a..g
	function automatic logic [8:0] glyph(input logic [7:0] c);
		logic [8:0] g;
		case (c)
			8'h30: g = 9'h13F;
			8'h31: g = 9'h106;
			8'h32: g = 9'h15B;
			8'h33: g = 9'h14F;
			8'h34: g = 9'h166;
			8'h35: g = 9'h16D;
			8'h36: g = 9'h17D;
			8'h37: g = 9'h107;
			8'h38: g = 9'h17F;
			8'h39: g = 9'h16F;
			8'h41: g = 9'h177;
			8'h43: g = 9'h139;
			8'h20: g = 9'h100;
			8'h72: g = 9'h150;
			8'h64: g = 9'h15E;
			8'h50: g = 9'h173;
			8'h6E: g = 9'h154;
			8'h6F: g = 9'h15C;
			8'h69: g = 9'h110;
			8'h49: g = 9'h130;
			CH_DASH: g = 9'h140;
			default: g = 9'h000;
		endcase
		return g;
	endfunction

endpackage

/* design/ssrd_roll_mem.sv */
// roll character store with a prefetching registered read port
// depends on ssrd_pkg
module ssrd_roll_mem #(
	parameter int ROLL_DEPTH = 64
) (
	input  logic               clk,
	input  ssrd_pkg::mem_req_t req,
	output logic [7:0]         rd_data
);
	localparam int AW = $clog2(ROLL_DEPTH);

	logic [7:0] mem [ROLL_DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// read every cycle so the word at the next roll position is always ready
	always_ff @(posedge clk) begin
		if (req.we && req.waddr == req.raddr) begin
			rd_q <= req.wdata;
		end else if (req.raddr < ssrd_pkg::CNT_W'(ROLL_DEPTH)) begin
			rd_q <= mem[req.raddr[AW-1:0]];
		end
	end

	assign rd_data = rd_q;
endmodule

/* design/ssrd_core.sv */
// display state, scan, roll and load logic for one word per cycle while fire is set
// depends on ssrd_pkg and assert_macros.svh
`include "assert_macros.svh"
module ssrd_core #(
	parameter int ROLL_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  ssrd_pkg::item_t    item,
	input  logic [3:0]         brightness_level,
	input  logic [7:0]         rd_data,
	output ssrd_pkg::res_t     res,
	output ssrd_pkg::mem_req_t req
);
	localparam int CW = ssrd_pkg::CNT_W;

	logic [3:0][7:0] msg_q, msg_d;
	logic [3:0][7:0] rst_buf_q, rst_buf_d;
	logic [CW-1:0]   len_q, len_d, pos_q, pos_d, lc_q, lc_d, len_eff;
	logic            rolling_q, rolling_d;
	logic [2:0]      point_q, point_d;
	logic [2:0]      lit_line_q, lit_line_d, blank_line_q, blank_line_d, line;
	logic [3:0]      dim_q, dim_d, dim_step;
	logic [7:0]      last_pat_q, last_pat_d, pat, ch;
	logic [8:0]      gl;
	logic            lit;

	always_comb begin
		lit = dim_q < brightness_level;
		line = lit ? lit_line_q : blank_line_q;
		dim_step = (dim_q == 4'd0) ? ssrd_pkg::DIM_TOP : dim_q - 4'd1;
		ch = msg_q[line[1:0]];
		gl = ssrd_pkg::glyph(ch);
		if (!lit) begin
			pat = 8'h00;
		end else if (ch == ssrd_pkg::CH_PERIOD) begin
			pat = ssrd_pkg::SEG_POINT;
		end else if (gl[8]) begin
			pat = {line == point_q, gl[6:0]};
		end else begin
			pat = last_pat_q;
		end
		res.valid = item.op == ssrd_pkg::OP_SCAN && !line[2];
		res.digit_select = line[1:0];
		res.segments = pat;
	end

	always_comb begin
		msg_d = msg_q;
		rst_buf_d = rst_buf_q;
		len_d = len_q;
		pos_d = pos_q;
		lc_d = lc_q;
		rolling_d = rolling_q;
		point_d = point_q;
		lit_line_d = lit_line_q;
		blank_line_d = blank_line_q;
		dim_d = dim_q;
		last_pat_d = last_pat_q;
		len_eff = (lc_q == '0) ? '0 : len_q;
		req.we = 1'b0;
		req.waddr = len_eff;
		req.wdata = item.char0;
		if (fire) begin
			case (item.op)
				ssrd_pkg::OP_SCAN: begin
					if (!line[2]) begin
						last_pat_d = pat;
						if (lit) lit_line_d = lit_line_q + 3'd1;
						else blank_line_d = blank_line_q + 3'd1;
					end else begin
						dim_d = dim_step;
						if (lit) lit_line_d = 3'd0;
						else blank_line_d = 3'd0;
					end
				end
				ssrd_pkg::OP_ROLL: begin
					if (rolling_q) begin
						if (pos_q < len_q) begin
							msg_d = {rd_data, msg_q[3:1]};
							pos_d = pos_q + CW'(1);
						end else begin
							msg_d = rst_buf_q;
							pos_d = '0;
						end
					end
				end
				ssrd_pkg::OP_WRITE: begin
					msg_d = {item.char3, item.char2, item.char1, item.char0};
					point_d = item.point_position;
					rolling_d = 1'b0;
					lc_d = '0;
				end
				default: begin
					len_d = len_eff;
					if (lc_q == '0) rolling_d = 1'b0;
					if (lc_q < CW'(4)) begin
						msg_d[lc_q[1:0]] = item.char0;
						rst_buf_d[lc_q[1:0]] = item.char0;
					end else if (len_eff < CW'(ROLL_DEPTH)) begin
						req.we = 1'b1;
						len_d = len_eff + CW'(1);
					end
					if (lc_q < ssrd_pkg::LOAD_MAX) lc_d = lc_q + CW'(1);
					if (item.last_char) begin
						rolling_d = 1'b1;
						pos_d = '0;
						lc_d = '0;
					end
				end
			endcase
		end
		req.raddr = pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_q <= {ssrd_pkg::CH_A, ssrd_pkg::CH_C, ssrd_pkg::CH_ZERO, ssrd_pkg::CH_EIGHT};
			rst_buf_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			lc_q <= '0;
			rolling_q <= 1'b0;
			point_q <= ssrd_pkg::NO_POINT;
			lit_line_q <= 3'd0;
			blank_line_q <= 3'd0;
			dim_q <= ssrd_pkg::DIM_TOP;
			last_pat_q <= 8'h00;
		end else begin
			msg_q <= msg_d;
			rst_buf_q <= rst_buf_d;
			len_q <= len_d;
			pos_q <= pos_d;
			lc_q <= lc_d;
			rolling_q <= rolling_d;
			point_q <= point_d;
			lit_line_q <= lit_line_d;
			blank_line_q <= blank_line_d;
			dim_q <= dim_d;
			last_pat_q <= last_pat_d;
		end
	end

	`SSRD_NEVER(a_dim_range, clk, arst_n, dim_q > ssrd_pkg::DIM_TOP)
	`SSRD_NEVER(a_len_range, clk, arst_n, len_q > CW'(ROLL_DEPTH))
	`SSRD_ASSERT(a_pos_in_msg, clk, arst_n, rolling_q |-> pos_q <= len_q)
	`SSRD_ASSERT(a_store_write, clk, arst_n, req.we |-> (fire && lc_q >= CW'(4)))
endmodule

/* design/seven_segment_scan_roll_dimmer_unit.sv */
// Four-digit multiplexed seven-segment display driver with roll and dimming.
// Input words arrive on the s_axis channel: tuser carries the operation (scan tick,
// roll tick, static message write, roll character load), tlast marks the final
// roll character, and tdata carries the four characters and the point position.
// Each scan tick that drives a digit produces one word on m_axis with the digit
// select and the segment pattern; wrap ticks, roll ticks, writes and loads
// produce none. The brightness level is written over the cfg channel while idle;
// the user must keep to this, the block does not enforce it. A word waits in the
// input register, where all state is updated and the result computed, and the result
// is held in the output register. One word per cycle is sustained unless m_axis stalls.
// The roll store is read one word ahead of the roll position so a roll tick
// never waits on the memory port.
// When the receiver stalls, a waiting result holds and words that give no result
// still pass; a scan word that would give one waits in the input register.
// Reset clears all control state and restores the message 8 0 C A; no
// clearing pass is needed, the roll store is only read where it was written.
// depends on ssrd_pkg, ssrd_core, ssrd_roll_mem and assert_macros.svh
`include "assert_macros.svh"
module seven_segment_scan_roll_dimmer_unit #(
	parameter int ROLL_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,       // brightness_level
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // char0, char1, char2, char3, point_position, zero pad
	input  logic [1:0]  s_axis_tuser,   // op
	input  logic        s_axis_tlast,   // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // digit_select, segments, zero pad
);
	logic               s1_valid_q;
	ssrd_pkg::item_t    item_s1;
	logic [3:0]         bright_q;
	logic               fire;
	ssrd_pkg::res_t     res;
	ssrd_pkg::mem_req_t req;
	logic [7:0]         rd_data;
	logic [1:0]         digit_q;
	logic [7:0]         seg_q;

	assign cfg_ready = 1'b1;
	assign fire = s1_valid_q && (!res.valid || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= ssrd_pkg::BRIGHT_RESET;
		end else if (cfg_valid) begin
			bright_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
				s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[34:32],
				s_axis_tlast};
		end
	end

	ssrd_core #(.ROLL_DEPTH(ROLL_DEPTH)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.brightness_level(bright_q),
		.rd_data(rd_data),
		.res(res),
		.req(req)
	);

	ssrd_roll_mem #(.ROLL_DEPTH(ROLL_DEPTH)) u_mem (
		.clk(clk),
		.req(req),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (fire && res.valid) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			digit_q <= res.digit_select;
			seg_q <= res.segments;
		end
	end

	assign m_axis_tdata = {6'd0, seg_q, digit_q};

	`SSRD_ASSERT(a_empty_ready, clk, arst_n, !s1_valid_q |-> s_axis_tready)
	`SSRD_ASSERT(a_result_loaded, clk, arst_n, (fire && res.valid) |=> m_axis_tvalid)
	`SSRD_ASSERT(a_no_overwrite, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |-> !(fire && res.valid))
endmodule
